>>> design/ssdc_pkg.sv
// ----------------------------------------------------------------------------
// ssdc_pkg
// Types, constants, microcode and arithmetic helpers of the skid-steer
// drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdc_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_COMMAND = 2'd0;
	localparam logic [1:0] KIND_TICK    = 2'd1;
	localparam logic [1:0] KIND_STOP    = 2'd2;
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_INV_MAX_SPEED = 3'd0;
	localparam logic [2:0] REG_HALF_WHEEL    = 3'd1;
	localparam logic [2:0] REG_SLEW_STEP     = 3'd2;
	localparam logic [2:0] REG_PWM_DEADZONE  = 3'd3;
	localparam logic [2:0] REG_PWM_MAX       = 3'd4;
	localparam logic [2:0] REG_CMD_TIMEOUT   = 3'd5;

	localparam int unsigned PADDR_W = 5;

	// Magnitude is unsigned Q.24; below 0.02 the motor coasts.
	localparam logic [24:0] MAG_ONE     = 25'h100_0000;
	localparam logic [24:0] COAST_LIMIT = 25'd335545;

	typedef struct packed {
		logic [1:0]         kind;
		logic [31:0]        now_ms;
		logic signed [15:0] linear_speed;
		logic signed [15:0] turn_rate;
	} item_t;

	typedef struct packed {
		logic [7:0]  left_pwm;
		logic        left_fwd;
		logic        left_rev;
		logic [7:0]  right_pwm;
		logic        right_fwd;
		logic        right_rev;
		logic [31:0] ms_since_command;
		logic        watchdog_expired;
	} result_t;

	typedef struct packed {
		logic [7:0] pwm;
		logic       fwd;
		logic       rev;
	} side_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_NONE  = 3'd0,
		MUL_TURN  = 3'd1,
		MUL_ABS_L = 3'd2,
		MUL_ABS_R = 3'd3,
		MUL_SCALE = 3'd4
	} mul_sel_t;

	// One control word of the sequencer program.
	typedef struct packed {
		mul_sel_t mul;
		logic     mix;
		logic     wdog;
		logic     stop;
		logic     slew;
		logic     fin_l;
		logic     emit;
		logic     coast;
		logic     last;
	} uword_t;

	localparam int unsigned PC_W = 4;

	// Program entry points.
	localparam logic [PC_W-1:0] PC_COMMAND = 4'd0;
	localparam logic [PC_W-1:0] PC_TICK    = 4'd2;
	localparam logic [PC_W-1:0] PC_STOP    = 4'd9;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{mul: MUL_NONE, default: 1'b0};
		case (pc)
			4'd0: w.mul = MUL_TURN;
			4'd1: begin
				w.mix  = 1'b1;
				w.last = 1'b1;
			end
			4'd2: w.wdog = 1'b1;
			4'd3: w.slew = 1'b1;
			4'd4: w.mul = MUL_ABS_L;
			4'd5: w.mul = MUL_SCALE;
			4'd6: begin
				w.fin_l = 1'b1;
				w.mul   = MUL_ABS_R;
			end
			4'd7: w.mul = MUL_SCALE;
			4'd8: begin
				w.emit = 1'b1;
				w.last = 1'b1;
			end
			4'd9: w.stop = 1'b1;
			4'd10: begin
				w.emit  = 1'b1;
				w.coast = 1'b1;
				w.last  = 1'b1;
			end
			default: w.last = 1'b1;
		endcase
		return w;
	endfunction

	function automatic logic [PC_W-1:0] entry_of(input logic [1:0] kind);
		logic [PC_W-1:0] pc;
		case (kind)
			KIND_COMMAND: pc = PC_COMMAND;
			KIND_TICK:    pc = PC_TICK;
			default:      pc = PC_STOP;
		endcase
		return pc;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] slew_toward(input logic signed [15:0] cur,
			input logic signed [15:0] tgt, input logic [14:0] step);
		logic signed [16:0] d;
		logic signed [16:0] stp;
		logic signed [16:0] sum;
		d   = {tgt[15], tgt} - {cur[15], cur};
		stp = {2'b00, step};
		if (d > stp) begin
			d = stp;
		end else if (d < -stp) begin
			d = -stp;
		end
		sum = {cur[15], cur} + d;
		return sum[15:0];
	endfunction

	// Bridge drive for one side; prod holds (max - deadzone) * mag.
	function automatic side_t drive_side(input logic signed [15:0] speed,
			input logic [24:0] mag, input logic [32:0] prod,
			input logic [7:0] dz, input logic [7:0] mx);
		side_t s;
		logic [8:0] sum;
		sum = {1'b0, dz} + {1'b0, prod[31:24]};
		if (mag < COAST_LIMIT) begin
			s = '0;
		end else begin
			if (mx < dz) begin
				s.pwm = mx;
			end else if (sum > {1'b0, mx}) begin
				s.pwm = mx;
			end else begin
				s.pwm = sum[7:0];
			end
			s.fwd = ~speed[15];
			s.rev = speed[15];
		end
		return s;
	endfunction

endpackage

`default_nettype wire

>>> design/skid_steer_drive_controller_core.sv
// ----------------------------------------------------------------------------
// skid_steer_drive_controller_core
// Skid-steer mixer with command watchdog, slew limit and PWM dead zone.
// ----------------------------------------------------------------------------
// Each item kind runs a short microcode program, and no new item is accepted
// until it ends; a tick or stop waits further while the result register
// still holds an untaken result. The program drives one shared 18 x 26 bit
// multiplier, used once for a command and four times for a tick (magnitude
// and PWM scaling for each side). Kind 3 is accepted and dropped without
// starting the sequencer.
// Configuration writes go through the APB port at byte address 4*index and
// take effect at once; they are meant for idle periods only.
`default_nettype none

module skid_steer_drive_controller_core #(
	parameter int unsigned PWM_BITS = 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	output logic                             item_stall,
	input  wire  ssdc_pkg::item_t            item,
	output logic                             result_valid,
	input  wire                              result_stall,
	output ssdc_pkg::result_t                result,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [ssdc_pkg::PADDR_W-1:0]     paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import ssdc_pkg::*;

	localparam logic [7:0] PWM_MASK = (PWM_BITS >= 8) ? 8'hFF : 8'((1 << PWM_BITS) - 1);

	// Configuration registers.
	logic [15:0] inv_max_q;
	logic [15:0] half_wheel_q;
	logic [14:0] slew_step_q;
	logic [7:0]  deadzone_q;
	logic [7:0]  pwm_max_q;
	logic [31:0] timeout_q;

	logic [2:0] reg_idx;
	logic       cfg_write;

	assign reg_idx   = paddr[PADDR_W-1:2];
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_max_q    <= 16'd4096;
			half_wheel_q <= 16'd6554;
			slew_step_q  <= 15'd205;
			deadzone_q   <= 8'd60 & PWM_MASK;
			pwm_max_q    <= 8'd255 & PWM_MASK;
			timeout_q    <= 32'd500;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_INV_MAX_SPEED: inv_max_q    <= pwdata[15:0];
				REG_HALF_WHEEL:    half_wheel_q <= pwdata[15:0];
				REG_SLEW_STEP:     slew_step_q  <= pwdata[14:0];
				REG_PWM_DEADZONE:  deadzone_q   <= pwdata[7:0] & PWM_MASK;
				REG_PWM_MAX:       pwm_max_q    <= pwdata[7:0] & PWM_MASK;
				REG_CMD_TIMEOUT:   timeout_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INV_MAX_SPEED: prdata = {16'd0, inv_max_q};
			REG_HALF_WHEEL:    prdata = {16'd0, half_wheel_q};
			REG_SLEW_STEP:     prdata = {17'd0, slew_step_q};
			REG_PWM_DEADZONE:  prdata = {24'd0, deadzone_q};
			REG_PWM_MAX:       prdata = {24'd0, pwm_max_q};
			REG_CMD_TIMEOUT:   prdata = timeout_q;
			default:           prdata = '0;
		endcase
	end

	// Sequencer.
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	uword_t          uw;
	logic            hold;
	logic            step;
	logic            accept;

	assign uw         = ucode(pc_q);
	assign hold       = uw.emit & result_valid & result_stall;
	assign step       = busy_q & ~hold;
	assign item_stall = busy_q;
	assign accept     = item_valid & ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (accept) begin
			// Kind 3 changes nothing, so the sequencer is not started for it.
			busy_q <= (item.kind != KIND_IGNORED);
			pc_q   <= entry_of(item.kind);
		end else if (step) begin
			if (uw.last) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// Item latched at the transfer.
	item_t item_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// Vehicle state.
	logic signed [15:0] left_tgt_q;
	logic signed [15:0] right_tgt_q;
	logic signed [15:0] left_spd_q;
	logic signed [15:0] right_spd_q;
	logic [31:0]        last_cmd_q;

	// Shared multiplier and working registers.
	logic signed [17:0] mul_a;
	logic [24:0]        mul_b;
	logic signed [43:0] mul_p;
	logic signed [32:0] prod_q;
	logic [24:0]        mag_n;
	logic [24:0]        mag_q;
	logic [7:0]         span;

	assign span  = pwm_max_q - deadzone_q;
	assign mag_n = ($unsigned(prod_q) > {8'd0, MAG_ONE}) ? MAG_ONE : prod_q[24:0];

	always_comb begin
		case (uw.mul)
			MUL_TURN: begin
				mul_a = {{2{item_q.turn_rate[15]}}, item_q.turn_rate};
				mul_b = {9'd0, half_wheel_q};
			end
			MUL_ABS_L: begin
				mul_a = left_spd_q[15] ? -{{2{left_spd_q[15]}}, left_spd_q}
					: {2'b00, left_spd_q};
				mul_b = {9'd0, inv_max_q};
			end
			MUL_ABS_R: begin
				mul_a = right_spd_q[15] ? -{{2{right_spd_q[15]}}, right_spd_q}
					: {2'b00, right_spd_q};
				mul_b = {9'd0, inv_max_q};
			end
			MUL_SCALE: begin
				mul_a = {10'd0, span};
				mul_b = mag_n;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * $signed({1'b0, mul_b});

	always_ff @(posedge clk) begin
		if (step && uw.mul != MUL_NONE) begin
			prod_q <= mul_p[32:0];
		end
		if (step && uw.mul == MUL_SCALE) begin
			mag_q <= mag_n;
		end
	end

	// Mixing and watchdog arithmetic.
	logic signed [16:0] turn_term;
	logic signed [17:0] left_mix;
	logic signed [17:0] right_mix;
	logic [31:0]        since;

	assign turn_term = prod_q[32:16];
	assign left_mix  = {{2{item_q.linear_speed[15]}}, item_q.linear_speed}
		- {turn_term[16], turn_term};
	assign right_mix = {{2{item_q.linear_speed[15]}}, item_q.linear_speed}
		+ {turn_term[16], turn_term};
	assign since     = item_q.now_ms - last_cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_tgt_q  <= '0;
			right_tgt_q <= '0;
			left_spd_q  <= '0;
			right_spd_q <= '0;
			last_cmd_q  <= '0;
		end else if (step) begin
			if (uw.mix) begin
				left_tgt_q  <= sat16(left_mix);
				right_tgt_q <= sat16(right_mix);
				last_cmd_q  <= item_q.now_ms;
			end
			if (uw.wdog && since > timeout_q) begin
				left_tgt_q  <= '0;
				right_tgt_q <= '0;
			end
			if (uw.slew) begin
				left_spd_q  <= slew_toward(left_spd_q, left_tgt_q, slew_step_q);
				right_spd_q <= slew_toward(right_spd_q, right_tgt_q, slew_step_q);
			end
			if (uw.stop) begin
				left_tgt_q  <= '0;
				right_tgt_q <= '0;
				left_spd_q  <= '0;
				right_spd_q <= '0;
			end
		end
	end

	// Result staging: the left side is registered at an earlier step than the transfer.
	side_t       left_q;
	logic [31:0] since_q;
	logic        expired_q;
	side_t       right_n;

	always_ff @(posedge clk) begin
		if (step) begin
			if (uw.wdog || uw.stop) begin
				since_q   <= since;
				expired_q <= uw.wdog & (since > timeout_q);
			end
			if (uw.fin_l) begin
				left_q <= drive_side(left_spd_q, mag_q, prod_q, deadzone_q, pwm_max_q);
			end
			if (uw.stop) begin
				left_q <= '0;
			end
		end
	end

	assign right_n = uw.coast ? side_t'('0)
		: drive_side(right_spd_q, mag_q, prod_q, deadzone_q, pwm_max_q);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (step && uw.emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && uw.emit) begin
			result.left_pwm         <= left_q.pwm;
			result.left_fwd         <= left_q.fwd;
			result.left_rev         <= left_q.rev;
			result.right_pwm        <= right_n.pwm;
			result.right_fwd        <= right_n.fwd;
			result.right_rev        <= right_n.rev;
			result.ms_since_command <= since_q;
			result.watchdog_expired <= expired_q;
		end
	end

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the skid-steer drive controller core. Velocity
// commands, control ticks and hard stops are sent over the item channel.
// A scoreboard keeps its own copy of the drive state and register values and
// predicts every PWM/direction result. It compares each result transfer
// field by field. The run steps through several register setups, among them
// both extremes. Both channels idle in random bursts, except in the final
// phase.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ssdc_pkg::*;

	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam int unsigned SETTLE_CYCLES = 12;

	class drive_scoreboard;
		logic [15:0]        inv_max_speed;
		logic [15:0]        half_track;
		logic [14:0]        slew_limit;
		logic [7:0]         duty_floor;
		logic [7:0]         duty_ceiling;
		logic [31:0]        timeout_ms;
		logic signed [15:0] tgt_l, tgt_r, spd_l, spd_r;
		logic [31:0]        last_cmd_ms;
		result_t            awaited[$];
		int                 errors;

		function new();
			inv_max_speed = 16'd4096;
			half_track    = 16'd6554;
			slew_limit    = 15'd205;
			duty_floor    = 8'd60;
			duty_ceiling  = 8'd255;
			timeout_ms    = 32'd500;
			tgt_l = '0; tgt_r = '0; spd_l = '0; spd_r = '0;
			last_cmd_ms = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_INV_MAX_SPEED: inv_max_speed = value[15:0];
				REG_HALF_WHEEL:    half_track    = value[15:0];
				REG_SLEW_STEP:     slew_limit    = value[14:0];
				REG_PWM_DEADZONE:  duty_floor    = value[7:0];
				REG_PWM_MAX:       duty_ceiling  = value[7:0];
				REG_CMD_TIMEOUT:   timeout_ms    = value;
				default: ;
			endcase
		endfunction

		function logic signed [15:0] clip16(int v);
			if (v > 32767) return 16'sh7FFF;
			if (v < -32768) return 16'sh8000;
			return v[15:0];
		endfunction

		function logic signed [15:0] step_toward(logic signed [15:0] cur,
				logic signed [15:0] tgt);
			int d;
			int lim;
			int sum;
			d   = int'(tgt) - int'(cur);
			lim = int'(slew_limit);
			if (d > lim) d = lim;
			if (d < -lim) d = -lim;
			sum = int'(cur) + d;
			return sum[15:0];
		endfunction

		function side_t bridge(logic signed [15:0] spd);
			side_t s;
			int a;
			longint unsigned mag;
			longint unsigned duty;
			a = int'(spd);
			if (a < 0) a = -a;
			mag = 64'(a) * 64'(inv_max_speed);
			if (mag > MAG_ONE) mag = MAG_ONE;
			s = '0;
			if (mag >= COAST_LIMIT) begin
				if (duty_ceiling < duty_floor) begin
					s.pwm = duty_ceiling;
				end else begin
					duty = 64'(duty_floor) + ((64'(duty_ceiling - duty_floor) * mag) >> 24);
					if (duty > duty_ceiling) duty = duty_ceiling;
					s.pwm = duty[7:0];
				end
				s.fwd = (spd >= 0);
				s.rev = (spd < 0);
			end
			return s;
		endfunction

		// Called at the clock edge where an item transfer takes place.
		function void note_item(item_t it);
			result_t r;
			side_t sl;
			side_t sr;
			longint prod;
			int turn_part;
			r = '0;
			r.ms_since_command = it.now_ms - last_cmd_ms;
			case (it.kind)
				KIND_COMMAND: begin
					prod = longint'(it.turn_rate) * longint'(half_track);
					turn_part = int'(prod >>> 16);
					tgt_l = clip16(int'(it.linear_speed) - turn_part);
					tgt_r = clip16(int'(it.linear_speed) + turn_part);
					last_cmd_ms = it.now_ms;
				end
				KIND_TICK: begin
					if (r.ms_since_command > timeout_ms) begin
						tgt_l = '0;
						tgt_r = '0;
						r.watchdog_expired = 1'b1;
					end
					spd_l = step_toward(spd_l, tgt_l);
					spd_r = step_toward(spd_r, tgt_r);
					sl = bridge(spd_l);
					sr = bridge(spd_r);
					r.left_pwm  = sl.pwm;
					r.left_fwd  = sl.fwd;
					r.left_rev  = sl.rev;
					r.right_pwm = sr.pwm;
					r.right_fwd = sr.fwd;
					r.right_rev = sr.rev;
					awaited.push_back(r);
				end
				KIND_STOP: begin
					tgt_l = '0; tgt_r = '0; spd_l = '0; spd_r = '0;
					awaited.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void match(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result transfer with nothing expected, actual %h", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			match("left_pwm", want.left_pwm, got.left_pwm);
			match("left_fwd", want.left_fwd, got.left_fwd);
			match("left_rev", want.left_rev, got.left_rev);
			match("right_pwm", want.right_pwm, got.right_pwm);
			match("right_fwd", want.right_fwd, got.right_fwd);
			match("right_rev", want.right_rev, got.right_rev);
			match("ms_since_command", want.ms_since_command, got.ms_since_command);
			match("watchdog_expired", want.watchdog_expired, got.watchdog_expired);
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	drive_scoreboard book = new();
	logic [31:0]     clock_ms;
	int unsigned     gap_cap;
	bit              calm;

	skid_steer_drive_controller_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// Valid stays high after a transfer; the next call either lowers it for a
	// gap or presents the next item in the same step, never both.
	task automatic send_item(input item_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		book.note_item(it);
	endtask

	task automatic put(input logic [1:0] kind, input logic [31:0] now,
			input logic signed [15:0] lin, input logic signed [15:0] turn);
		item_t it;
		it.kind = kind;
		it.now_ms = now;
		it.linear_speed = lin;
		it.turn_rate = turn;
		clock_ms = now;
		send_item(it);
	endtask

	// A command leaves no result behind, so give the block time to finish it.
	task automatic settle();
		item_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setup(input logic [31:0] inv, input logic [31:0] half,
			input logic [31:0] slew, input logic [31:0] dz, input logic [31:0] mx,
			input logic [31:0] tmo);
		settle();
		cfg_write(REG_INV_MAX_SPEED, inv);
		cfg_write(REG_HALF_WHEEL, half);
		cfg_write(REG_SLEW_STEP, slew);
		cfg_write(REG_PWM_DEADZONE, dz);
		cfg_write(REG_PWM_MAX, mx);
		cfg_write(REG_CMD_TIMEOUT, tmo);
		gap_cap = (book.timeout_ms > 3000) ? 1000 : book.timeout_ms / 3 + 1;
	endtask

	function automatic item_t random_item();
		item_t it;
		int unsigned roll;
		int lin;
		int turn;
		roll = $urandom_range(0, 99);
		if (roll < 72) begin
			clock_ms += $urandom_range(0, gap_cap);
		end else if (roll < 92) begin
			// Land right around the watchdog boundary.
			clock_ms = book.last_cmd_ms + book.timeout_ms - 2 + $urandom_range(0, 4);
		end else begin
			clock_ms = $urandom();
		end
		roll = $urandom_range(0, 99);
		if (roll < 30) it.kind = KIND_COMMAND;
		else if (roll < 88) it.kind = KIND_TICK;
		else if (roll < 96) it.kind = KIND_STOP;
		else it.kind = KIND_IGNORED;
		it.now_ms = clock_ms;
		if (it.kind == KIND_COMMAND && $urandom_range(0, 3) != 0) begin
			lin  = int'($urandom_range(0, 16384)) - 8192;
			turn = int'($urandom_range(0, 32768)) - 16384;
			it.linear_speed = lin[15:0];
			it.turn_rate    = turn[15:0];
		end else begin
			it.linear_speed = 16'($urandom());
			it.turn_rate    = 16'($urandom());
		end
		return it;
	endfunction

	task automatic run_phase(input int count);
		item_t it;
		int done;
		done = 0;
		while (done < count) begin
			it = random_item();
			send_item(it);
			if (it.kind != KIND_IGNORED) done++;
		end
	endtask

	initial begin : result_side
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) book.check_result(result);
			if (calm) begin
				result_stall <= 1'b0;
			end else if (hold != 0) begin
				hold--;
			end else if ($urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 8);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int phase;
		logic [31:0] dz;
		logic [31:0] mx;
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		clock_ms = '0;
		gap_cap = 167;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset register values.
		put(KIND_TICK, 32'd0, 16'sd0, 16'sd0);
		put(KIND_COMMAND, 32'd10, 16'sh7FFF, 16'sh7FFF);
		put(KIND_TICK, 32'd20, 16'sd0, 16'sd0);
		put(KIND_COMMAND, 32'd30, 16'sh8000, 16'sh7FFF);
		put(KIND_TICK, 32'd40, 16'sd0, 16'sd0);
		put(KIND_COMMAND, 32'd50, 16'sh8000, 16'sh8000);
		put(KIND_TICK, 32'd60, 16'sd0, 16'sd0);
		// A negative turn rounds toward minus infinity.
		put(KIND_COMMAND, 32'd100, 16'sd4096, -16'sd1);
		put(KIND_TICK, 32'd600, 16'sd0, 16'sd0);
		put(KIND_TICK, 32'd601, 16'sd0, 16'sd0);
		put(KIND_STOP, 32'd602, 16'sd0, 16'sd0);
		put(KIND_IGNORED, 32'd603, 16'sh5A5A, 16'shA5A5);
		put(KIND_COMMAND, 32'hFFFF_FFF0, -16'sd4096, 16'sd1);
		put(KIND_TICK, 32'h0000_0010, 16'sd0, 16'sd0);
		put(KIND_TICK, 32'h0000_0008, 16'sd0, 16'sd0);
		put(KIND_STOP, 32'h0000_0030, 16'sd0, 16'sd0);
		// Speeds just above and just below the coast threshold.
		put(KIND_COMMAND, 32'h0000_0040, 16'sd82, 16'sd0);
		put(KIND_TICK, 32'h0000_0050, 16'sd0, 16'sd0);
		put(KIND_COMMAND, 32'h0000_0060, 16'sd81, 16'sd0);
		put(KIND_TICK, 32'h0000_0070, 16'sd0, 16'sd0);
		run_phase(200);

		apply_setup(32'd65535, 32'd65535, 32'd32767, 32'd255, 32'd255, 32'hFFFF_FFFF);
		run_phase(150);

		apply_setup(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		run_phase(120);

		// Zero scale always coasts; a dead zone above the maximum clips to it.
		apply_setup(32'd0, 32'd3000, 32'd1000, 32'd100, 32'd50, 32'd1000);
		cfg_write(REG_SPARE_A, $urandom());
		cfg_write(REG_SPARE_B, $urandom());
		run_phase(120);

		for (phase = 0; phase < 5; phase++) begin
			dz = $urandom_range(0, 120);
			mx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				: $urandom_range(dz, 255);
			apply_setup($urandom_range(1000, 20000), $urandom(), $urandom_range(20, 3000),
				dz, mx, $urandom_range(20, 3000));
			run_phase(200);
		end

		apply_setup(32'd4096, 32'd6554, 32'd205, 32'd60, 32'd255, 32'd500);
		calm = 1'b1;
		run_phase(250);
		settle();
		repeat (20) @(posedge clk);

		if (book.errors == 0 && book.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> skid_steer_drive_controller_core.f
design/ssdc_pkg.sv
design/skid_steer_drive_controller_core.sv
bench/testbench.sv
